[hw/rtl/npp_pkg.sv]
// Shared types and constants for the nearest point proximity block.
`default_nettype none
package npp_pkg;
	localparam int MAX_POINTS_DEF = 32;
	localparam int COORD_BITS_DEF = 24;
	localparam int RADIUS_W       = 23;
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 23'd1600;
	localparam int DIFF_W         = 24;
	localparam logic [DIFF_W-1:0] DIFF_SAT = 24'h800000;
	localparam int SQ_W           = 48;
	localparam int DSQ_W          = 50;
	localparam int ROOT_W         = 25;
	localparam int REM_W          = 28;
	localparam int PROX_W         = 17;
	localparam int SQRT_STEPS     = 25;
	localparam int DIV_STEPS      = 16;
	localparam int DRAIN_CYCLES   = 4;
	localparam int CNT_W          = 5;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_QUERY = 2'd2
	} command_t;

	typedef struct packed {
		logic pt_wr;
		logic pt_clr;
		logic q_load;
		logic scan_step;
		logic sqrt_init;
		logic sqrt_step;
		logic div_init;
		logic div_step;
		logic res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} dp_stat_t;
endpackage
`default_nettype wire

[hw/rtl/npp_ctrl.sv]
// Controller state machine that sequences write, clear and query items.
`default_nettype none
module npp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       command,
	input  wire npp_pkg::dp_stat_t stat,
	output npp_pkg::dp_cmd_t      cmd
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DRAIN, ST_SQINIT, ST_SQRT, ST_DINIT, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;
	logic [npp_pkg::CNT_W-1:0] cnt_q;
	logic accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.pt_wr  = accept && (command == npp_pkg::CMD_WRITE);
		cmd.pt_clr = accept && (command == npp_pkg::CMD_CLEAR);
		cmd.q_load = accept && (command == npp_pkg::CMD_QUERY);
		cmd.scan_step = (state_q == ST_SCAN);
		cmd.sqrt_init = (state_q == ST_SQINIT);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.div_init  = (state_q == ST_DINIT);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.res_load  = (state_q == ST_OUT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.q_load) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.scan_last) begin
						state_q <= ST_DRAIN;
						cnt_q   <= '0;
					end
				end
				ST_DRAIN: begin
					// Let the last point leave the distance pipeline.
					if (cnt_q == npp_pkg::CNT_W'(npp_pkg::DRAIN_CYCLES - 1)) begin
						state_q <= ST_SQINIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQINIT: begin
					state_q <= ST_SQRT;
					cnt_q   <= '0;
				end
				ST_SQRT: begin
					if (cnt_q == npp_pkg::CNT_W'(npp_pkg::SQRT_STEPS - 1)) begin
						state_q <= ST_DINIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DINIT: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					if (cnt_q == npp_pkg::CNT_W'(npp_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

[hw/rtl/npp_dp.sv]
// Datapath: point table, distance pipeline, serial square root and divider.
`default_nettype none
module npp_dp #(
	parameter int MAX_POINTS = npp_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = npp_pkg::COORD_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire npp_pkg::dp_cmd_t                  cmd,
	output npp_pkg::dp_stat_t                      stat,
	input  wire logic                              cfg_we,
	input  wire logic [npp_pkg::RADIUS_W-1:0]      cfg_wdata,
	input  wire logic [4:0]                        point_slot,
	input  wire logic                              point_enable,
	input  wire logic signed [COORD_BITS-1:0]      pos_x,
	input  wire logic signed [COORD_BITS-1:0]      pos_y,
	input  wire logic signed [COORD_BITS-1:0]      pos_z,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [npp_pkg::PROX_W-1:0]             proximity,
	output logic                                   no_points
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PW = 3 * COORD_BITS;
	localparam int EW = (COORD_BITS + 1 > npp_pkg::DIFF_W) ? COORD_BITS + 1 : npp_pkg::DIFF_W;
	localparam int RW = npp_pkg::RADIUS_W;

	function automatic logic [npp_pkg::DIFF_W-1:0] abs_diff_sat(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] d;
		logic [COORD_BITS:0] m;
		logic [EW-1:0] me;
		begin
			d  = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
			m  = d[COORD_BITS] ? (COORD_BITS + 1)'(-d) : (COORD_BITS + 1)'(d);
			me = EW'(m);
			if (me > EW'(npp_pkg::DIFF_SAT)) begin
				abs_diff_sat = npp_pkg::DIFF_SAT;
			end else begin
				abs_diff_sat = me[npp_pkg::DIFF_W-1:0];
			end
		end
	endfunction

	// Point table and valid marks.
	logic [PW-1:0] pts_mem [MAX_POINTS];
	logic [MAX_POINTS-1:0] valid_q;
	logic [8:0] slot_w;
	logic [AW-1:0] slot_idx;
	logic slot_ok;
	logic [RW-1:0] radius_q;

	assign slot_w   = 9'(point_slot);
	assign slot_idx = slot_w[AW-1:0];
	assign slot_ok  = (slot_w < 9'(MAX_POINTS));

	always_ff @(posedge clk) begin
		if (cmd.pt_wr && slot_ok) begin
			pts_mem[slot_idx] <= {pos_x, pos_y, pos_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			radius_q <= npp_pkg::RADIUS_RST;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
			if (cmd.pt_clr) begin
				valid_q <= '0;
			end else if (cmd.pt_wr && slot_ok) begin
				valid_q[slot_idx] <= point_enable;
			end
		end
	end

	// Query position and scan address.
	logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
	logic [AW-1:0] addr_q;

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			qx_q <= pos_x;
			qy_q <= pos_y;
			qz_q <= pos_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (cmd.q_load) begin
			addr_q <= '0;
		end else if (cmd.scan_step) begin
			addr_q <= addr_q + 1'b1;
		end
	end

	assign stat.scan_last = (addr_q == AW'(MAX_POINTS - 1));

	// Distance pipeline: read, differences, squares, sum and minimum.
	logic [PW-1:0] pt_s1;
	logic v_s1, v_s2, v_s3;
	logic [npp_pkg::DIFF_W-1:0] dx_s2, dy_s2, dz_s2;
	logic [npp_pkg::SQ_W-1:0] sx_s3, sy_s3, sz_s3;
	logic [npp_pkg::DSQ_W-1:0] dsq;
	logic [npp_pkg::DSQ_W-1:0] best_q;
	logic found_q;

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			pt_s1 <= pts_mem[addr_q];
		end
		dx_s2 <= abs_diff_sat(qx_q, pt_s1[PW-1 -: COORD_BITS]);
		dy_s2 <= abs_diff_sat(qy_q, pt_s1[2*COORD_BITS-1 -: COORD_BITS]);
		dz_s2 <= abs_diff_sat(qz_q, pt_s1[COORD_BITS-1:0]);
		sx_s3 <= dx_s2 * dx_s2;
		sy_s3 <= dy_s2 * dy_s2;
		sz_s3 <= dz_s2 * dz_s2;
	end

	assign dsq = npp_pkg::DSQ_W'(sx_s3) + npp_pkg::DSQ_W'(sy_s3) + npp_pkg::DSQ_W'(sz_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			found_q <= 1'b0;
			best_q  <= '0;
		end else begin
			v_s1 <= cmd.scan_step && valid_q[addr_q];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.q_load) begin
				found_q <= 1'b0;
			end else if (v_s3 && (!found_q || dsq < best_q)) begin
				best_q  <= dsq;
				found_q <= 1'b1;
			end
		end
	end

	// Integer square root, one bit of the root per step.
	logic [npp_pkg::DSQ_W-1:0] sq_n_q;
	logic [npp_pkg::REM_W-1:0] sq_rem_q, rem_sh, trial;
	logic [npp_pkg::ROOT_W-1:0] root_q;

	assign rem_sh = {sq_rem_q[npp_pkg::REM_W-3:0], sq_n_q[npp_pkg::DSQ_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.sqrt_init) begin
			sq_n_q   <= best_q;
			sq_rem_q <= '0;
			root_q   <= '0;
		end else if (cmd.sqrt_step) begin
			sq_n_q <= {sq_n_q[npp_pkg::DSQ_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				sq_rem_q <= rem_sh - trial;
				root_q   <= {root_q[npp_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				sq_rem_q <= rem_sh;
				root_q   <= {root_q[npp_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	// Restoring divider for 65536 * (r - d) / r, one quotient bit per step.
	logic [RW-1:0] r_eff;
	logic [RW-1:0] div_rem_q;
	logic [RW:0] rem2;
	logic [npp_pkg::PROX_W-1:0] quo_q;
	logic far_q;

	assign r_eff = (radius_q == '0) ? RW'(1) : radius_q;
	assign rem2  = {div_rem_q, 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			far_q <= (root_q >= npp_pkg::ROOT_W'(r_eff));
			if (root_q == '0) begin
				quo_q     <= npp_pkg::PROX_W'(1);
				div_rem_q <= '0;
			end else begin
				quo_q     <= '0;
				div_rem_q <= r_eff - root_q[RW-1:0];
			end
		end else if (cmd.div_step) begin
			if (rem2 >= {1'b0, r_eff}) begin
				div_rem_q <= RW'(rem2 - {1'b0, r_eff});
				quo_q     <= {quo_q[npp_pkg::PROX_W-2:0], 1'b1};
			end else begin
				div_rem_q <= rem2[RW-1:0];
				quo_q     <= {quo_q[npp_pkg::PROX_W-2:0], 1'b0};
			end
		end
	end

	// Output register.
	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			no_points <= !found_q;
			proximity <= (!found_q || far_q) ? '0 : quo_q;
		end
	end

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid || out_ready))
		else $error("result loaded over an unaccepted result");
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.q_load && (cmd.pt_wr || cmd.pt_clr || cmd.scan_step)))
		else $error("query start overlaps table update or scan");
	a_found_clr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.q_load |=> !found_q)
		else $error("minimum search not cleared at query start");
	a_prox_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (proximity <= npp_pkg::PROX_W'(65536)))
		else $error("proximity above one");
endmodule
`default_nettype wire

[hw/rtl/nearest_point_proximity_unit.sv]
// Top level of the nearest point proximity unit.
// A write or clear item gives no result. For a query item the stored points
// are read one per cycle through the single read port of the point table into a
// four-stage distance pipeline, then the integer square root runs 25 steps and
// the divider 16 steps, one bit each. Items are taken only between queries;
// a finished result waits in the output register while the next item is taken.
// The radius register may be written whenever the unit is idle.
`default_nettype none
module nearest_point_proximity_unit #(
	parameter int MAX_POINTS = npp_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = npp_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [npp_pkg::RADIUS_W-1:0]  cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    command,
	input  wire logic [4:0]                    point_slot,
	input  wire logic                          point_enable,
	input  wire logic signed [COORD_BITS-1:0]  pos_x,
	input  wire logic signed [COORD_BITS-1:0]  pos_y,
	input  wire logic signed [COORD_BITS-1:0]  pos_z,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [npp_pkg::PROX_W-1:0]         proximity,
	output logic                               no_points
);
	npp_pkg::dp_cmd_t  cmd;
	npp_pkg::dp_stat_t stat;

	npp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.stat     (stat),
		.cmd      (cmd)
	);

	npp_dp #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.point_slot   (point_slot),
		.point_enable (point_enable),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.proximity    (proximity),
		.no_points    (no_points)
	);
endmodule
`default_nettype wire

[verif/nearest_point_proximity_unit_test.sv]
// Self-checking testbench for the nearest point proximity unit.
`default_nettype none
module nearest_point_proximity_unit_test;
	localparam int NPTS = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [4:0]         slot;
		logic               en;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
	} npp_item_t;

	typedef struct packed {
		logic [npp_pkg::PROX_W-1:0] prox;
		logic                       empty;
	} npp_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [npp_pkg::RADIUS_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [1:0] command;
	logic [4:0] point_slot;
	logic point_enable;
	logic signed [23:0] pos_x, pos_y, pos_z;
	logic out_valid;
	logic out_ready;
	logic [npp_pkg::PROX_W-1:0] proximity;
	logic no_points;

	nearest_point_proximity_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.point_slot(point_slot), .point_enable(point_enable),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.proximity(proximity), .no_points(no_points)
	);

	// Predictor state.
	logic signed [23:0] pt_x [NPTS];
	logic signed [23:0] pt_y [NPTS];
	logic signed [23:0] pt_z [NPTS];
	logic               pt_live [NPTS];
	logic [npp_pkg::RADIUS_W-1:0] radius;

	npp_item_t   pending_items[$];
	npp_result_t expected_results[$];
	int  mismatches = 0;
	int  items_taken = 0;
	int  results_seen = 0;
	int  queries_sent = 0;
	int  idle_cycles = 0;
	bit  calm = 0;
	bit  hold_off = 0;
	int  hold_count = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic [23:0] diff_mag(logic signed [23:0] a, logic signed [23:0] b);
		longint m;
		m = longint'(a) - longint'(b);
		if (m < 0) m = -m;
		if (m > 64'h800000) m = 64'h800000;
		return m[23:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	task automatic apply_item(npp_item_t it);
		longint unsigned best, dx, dy, dz, dsq, r, d;
		bit found;
		npp_result_t res;
		case (it.cmd)
			npp_pkg::CMD_WRITE: begin
				pt_x[it.slot] = it.x;
				pt_y[it.slot] = it.y;
				pt_z[it.slot] = it.z;
				pt_live[it.slot] = it.en;
			end
			npp_pkg::CMD_CLEAR: for (int i = 0; i < NPTS; i++) pt_live[i] = 0;
			npp_pkg::CMD_QUERY: begin
				found = 0;
				best = 0;
				for (int i = 0; i < NPTS; i++) begin
					if (pt_live[i]) begin
						dx = diff_mag(it.x, pt_x[i]);
						dy = diff_mag(it.y, pt_y[i]);
						dz = diff_mag(it.z, pt_z[i]);
						dsq = dx * dx + dy * dy + dz * dz;
						if (!found || dsq < best) best = dsq;
						found = 1;
					end
				end
				res.prox = 0;
				res.empty = !found;
				if (found) begin
					r = (radius == 0) ? 1 : radius;
					d = int_sqrt(best);
					if (d < r) res.prox = npp_pkg::PROX_W'((64'd65536 * (r - d)) / r);
				end
				expected_results.push_back(res);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	function automatic logic signed [23:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 24'sh7fffff;
			1: return 24'sh800000;
			2, 3: return 24'($signed($urandom_range(0, 4000)) - 2000);
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic npp_item_t make_item(logic [1:0] c, int s, bit e,
			logic signed [23:0] x, logic signed [23:0] y, logic signed [23:0] z);
		npp_item_t it;
		it.cmd = c; it.slot = 5'(s); it.en = e; it.x = x; it.y = y; it.z = z;
		return it;
	endfunction

	// Driver: presents the oldest pending item and holds it until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
		end else begin
			if (in_valid && in_ready) begin
				apply_item(pending_items.pop_front());
				items_taken++;
			end
			if (in_valid && !in_ready) begin
				// keep offering the same item
			end else if (pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
				in_valid <= 1;
				{command, point_slot, point_enable, pos_x, pos_y, pos_z} <= pending_items[0];
			end else begin
				in_valid <= 0;
			end
		end
	end

	// Monitor: checks each result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", proximity, -1);
			end else begin
				if (proximity !== expected_results[0].prox)
					report_mismatch("proximity", proximity, expected_results[0].prox);
				if (no_points !== expected_results[0].empty)
					report_mismatch("no_points", no_points, expected_results[0].empty);
				void'(expected_results.pop_front());
			end
		end
		if (hold_off) begin
			out_ready <= 0;
			hold_count++;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 12);
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_radius(logic [npp_pkg::RADIUS_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		radius = v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic queue_random(int n);
		int s;
		for (int k = 0; k < n; k++) begin
			s = $urandom_range(0, 99);
			if (s < 35)
				pending_items.push_back(make_item(npp_pkg::CMD_WRITE, $urandom_range(0, 31),
					$urandom_range(0, 5) != 0, rand_coord(), rand_coord(), rand_coord()));
			else if (s < 38)
				pending_items.push_back(make_item(npp_pkg::CMD_CLEAR, $urandom_range(0, 31),
					1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord()));
			else if (s < 40)
				pending_items.push_back(make_item(2'd3, $urandom_range(0, 31),
					1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord()));
			else begin
				pending_items.push_back(make_item(npp_pkg::CMD_QUERY, $urandom_range(0, 31),
					1'($urandom_range(0, 1)), rand_coord(), rand_coord(), rand_coord()));
				queries_sent++;
			end
		end
	endtask

	initial begin
		logic [npp_pkg::RADIUS_W-1:0] radii [5];
		radii = '{23'd0, 23'd1, 23'h7fffff, 23'd16, 23'($urandom_range(16, 100000))};
		for (int i = 0; i < NPTS; i++) begin
			pt_live[i] = 0; pt_x[i] = 0; pt_y[i] = 0; pt_z[i] = 0;
		end
		radius = npp_pkg::RADIUS_RST;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		in_valid = 0;
		out_ready = 0;
		command = 0; point_slot = 0; point_enable = 0;
		pos_x = 0; pos_y = 0; pos_z = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// Directed: empty table, extremes, invalidate, clear, unused command.
		pending_items.push_back(make_item(npp_pkg::CMD_QUERY, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(npp_pkg::CMD_WRITE, 0, 1, 0, 0, 0));
		pending_items.push_back(make_item(npp_pkg::CMD_QUERY, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(npp_pkg::CMD_QUERY, 0, 0, 800, 0, 0));
		pending_items.push_back(make_item(npp_pkg::CMD_QUERY, 0, 0, 1600, 0, 0));
		pending_items.push_back(make_item(npp_pkg::CMD_WRITE, 31, 1,
			24'sh7fffff, 24'sh7fffff, 24'sh7fffff));
		pending_items.push_back(make_item(npp_pkg::CMD_QUERY, 0, 0,
			24'sh800000, 24'sh800000, 24'sh800000));
		pending_items.push_back(make_item(npp_pkg::CMD_QUERY, 0, 0,
			24'sh7ffff0, 24'sh7fffff, 24'sh7fffff));
		pending_items.push_back(make_item(npp_pkg::CMD_WRITE, 0, 0, 5, 5, 5));
		pending_items.push_back(make_item(npp_pkg::CMD_QUERY, 0, 0, -1, -1, -1));
		pending_items.push_back(make_item(2'd3, 7, 1, -1, -1, -1));
		pending_items.push_back(make_item(npp_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(npp_pkg::CMD_QUERY, 31, 1,
			24'sh7fffff, 24'sh7fffff, 24'sh7fffff));
		pending_items.push_back(make_item(npp_pkg::CMD_WRITE, 3, 1, -100, 200, -300));
		pending_items.push_back(make_item(npp_pkg::CMD_WRITE, 4, 1, 100, 200, 300));
		pending_items.push_back(make_item(npp_pkg::CMD_QUERY, 0, 0, 90, 190, 290));
		drain();

		// Long receiver stall while items keep coming.
		calm = 1;
		hold_off = 1;
		queue_random(30);
		while (hold_count < 600) @(posedge clk);
		hold_off = 0;
		drain();
		calm = 0;

		// Random phases over a range of radius settings, extremes included.
		for (int p = 0; p < 5; p++) begin
			set_radius(radii[p]);
			if (p == 2) calm = 1;
			queue_random(160);
			drain();
			calm = 0;
		end

		$display("covered %0d items, %0d results checked, five radius settings",
			items_taken, results_seen);
		$display("includes an empty table, clears, slot invalidation and a long output stall");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
hw/rtl/npp_pkg.sv
hw/rtl/npp_ctrl.sv
hw/rtl/npp_dp.sv
hw/rtl/nearest_point_proximity_unit.sv
verif/nearest_point_proximity_unit_test.sv
